// ===== sv/trm_pkg.sv =====
// Shared widths, opcodes and print codes for the register machine execute core.
`default_nettype none

package trm_pkg;

    localparam int CMD_W  = 4;
    localparam int REG_W  = 4;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 9;
    localparam int KIND_W = 2;

    localparam logic [CMD_W-1:0] OP_MOV = 4'd1;
    localparam logic [CMD_W-1:0] OP_MOC = 4'd2;
    localparam logic [CMD_W-1:0] OP_ADD = 4'd3;
    localparam logic [CMD_W-1:0] OP_ADC = 4'd4;
    localparam logic [CMD_W-1:0] OP_SUB = 4'd5;
    localparam logic [CMD_W-1:0] OP_SUC = 4'd6;
    localparam logic [CMD_W-1:0] OP_JMP = 4'd7;
    localparam logic [CMD_W-1:0] OP_PTN = 4'd8;
    localparam logic [CMD_W-1:0] OP_PTC = 4'd9;

    typedef enum logic [KIND_W-1:0] {
        PRINT_NONE = 2'd0,
        PRINT_NUM  = 2'd1,
        PRINT_CHAR = 2'd2
    } t_print_kind;

endpackage

`default_nettype wire

// ===== sv/toy_register_machine_execute_core.sv =====
// Top level: one decoded instruction per request against the register file and program counter.
`default_nettype none

// Executes one decoded instruction per request and returns one result per
// request. Throughput is one request per cycle while the result is not
// stalled. The operand registers are read into an input stage at accept
// (with the write of the instruction executing in that same cycle
// forwarded), then add/subtract, jump target and PC update run in one pass
// into the result register. The register file resets to zero through one
// valid bit per register, so no clearing pass is needed. program_length is
// written through the config channel, always ready, by the user only while the
// core is idle (the core does not enforce this); done is flagged when next_pc >= program_length.
module toy_register_machine_execute_core #(
    parameter int NUM_REGS      = 13,
    parameter int PROGRAM_DEPTH = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_ready,
    input  wire logic [trm_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [trm_pkg::REG_W-1:0]        i_dest_reg,
    input  wire logic [trm_pkg::REG_W-1:0]        i_src_reg,
    input  wire logic signed [trm_pkg::DATA_W-1:0] i_immediate,
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [trm_pkg::LEN_W-1:0]        i_cfg_data,
    output      logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    output      logic [trm_pkg::LEN_W-1:0]        o_next_pc,
    output      logic [trm_pkg::KIND_W-1:0]       o_print_kind,
    output      logic signed [trm_pkg::DATA_W-1:0] o_print_value,
    output      logic                             o_program_done,
    output      logic                             o_fault
);

    localparam int DW    = trm_pkg::DATA_W;
    localparam int RW    = trm_pkg::REG_W;
    localparam int LW    = trm_pkg::LEN_W;
    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
    localparam int CMP_W = PC_W + LW;
    localparam logic [PC_W-1:0] PC_MAX    = PC_W'(PROGRAM_DEPTH);
    localparam logic [RW:0]     REG_LIMIT = (RW + 1)'(NUM_REGS);
    localparam logic signed [DW:0] TARGET_MAX = (DW + 1)'(PROGRAM_DEPTH);

    // handshakes
    logic in_fire;
    logic exec_fire;
    logic cfg_fire;

    // register file and its read stage
    logic [DW-1:0]       mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_reg_vld;
    logic [DW-1:0]       r_a_raw;
    logic [DW-1:0]       r_b_raw;
    logic                r_a_vld;
    logic                r_b_vld;
    logic                r_a_fwd;
    logic                r_b_fwd;
    logic [DW-1:0]       r_fwd_data;

    // input stage
    logic                r_in_valid;
    logic [trm_pkg::CMD_W-1:0] r_cmd;
    logic [RW-1:0]       r_rd;
    logic [RW-1:0]       r_rs;
    logic [DW-1:0]       r_imm;

    // architectural state
    logic [PC_W-1:0]     r_pc;
    logic [LW-1:0]       r_prog_len;

    // execute
    logic [DW-1:0]       op_a;
    logic [DW-1:0]       op_b;
    logic [DW-1:0]       op2;
    logic [DW-1:0]       alu;
    logic [DW-1:0]       wr_val;
    logic [IDX_W-1:0]    wr_idx;
    logic                we;
    logic                known;
    logic                uses_src;
    logic                wr_op;
    logic                is_sub;
    logic                is_jmp;
    logic                use_alu;
    trm_pkg::t_print_kind kind;
    trm_pkg::t_print_kind kind_eff;
    logic                idx_bad;
    logic                jump_taken;
    logic                jump_bad;
    logic                fault;
    logic signed [DW:0]  target;
    logic [PC_W-1:0]     pc_inc;
    logic [PC_W-1:0]     n_pc;
    logic [CMP_W-1:0]    pc_cmp;
    logic [CMP_W-1:0]    len_cmp;
    logic [CMP_W-1:0]    pc_out;

    // result register
    logic                r_out_valid;
    logic [LW-1:0]       r_next_pc;
    trm_pkg::t_print_kind r_kind;
    logic [DW-1:0]       r_pval;
    logic                r_done;
    logic                r_fault;

    assign exec_fire   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || exec_fire;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // operands: forwarded write first, then stored value, zero if never written
    assign op_a = r_a_fwd ? r_fwd_data : (r_a_vld ? r_a_raw : '0);
    assign op_b = r_b_fwd ? r_fwd_data : (r_b_vld ? r_b_raw : '0);

    always_comb begin
        known    = 1'b0;
        uses_src = 1'b0;
        wr_op    = 1'b0;
        is_sub   = 1'b0;
        is_jmp   = 1'b0;
        use_alu  = 1'b0;
        kind     = trm_pkg::PRINT_NONE;
        unique case (r_cmd) inside
            trm_pkg::OP_MOV: begin
                known    = 1'b1;
                uses_src = 1'b1;
                wr_op    = 1'b1;
            end
            trm_pkg::OP_MOC: begin
                known = 1'b1;
                wr_op = 1'b1;
            end
            trm_pkg::OP_ADD, trm_pkg::OP_SUB: begin
                known    = 1'b1;
                uses_src = 1'b1;
                wr_op    = 1'b1;
                use_alu  = 1'b1;
                is_sub   = (r_cmd == trm_pkg::OP_SUB);
            end
            trm_pkg::OP_ADC, trm_pkg::OP_SUC: begin
                known   = 1'b1;
                wr_op   = 1'b1;
                use_alu = 1'b1;
                is_sub  = (r_cmd == trm_pkg::OP_SUC);
            end
            trm_pkg::OP_JMP: begin
                known  = 1'b1;
                is_jmp = 1'b1;
            end
            trm_pkg::OP_PTN: begin
                known = 1'b1;
                kind  = trm_pkg::PRINT_NUM;
            end
            trm_pkg::OP_PTC: begin
                known = 1'b1;
                kind  = trm_pkg::PRINT_CHAR;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign op2 = uses_src ? op_b : r_imm;
    assign alu = is_sub ? (op_a - op2) : (op_a + op2);

    always_comb begin
        if (use_alu) begin
            wr_val = alu;
        end else if (uses_src) begin
            wr_val = op_b;
        end else begin
            wr_val = r_imm;
        end
    end

    assign idx_bad = ({1'b0, r_rd} >= REG_LIMIT) || (uses_src && ({1'b0, r_rs} >= REG_LIMIT));

    // jump target in signed 33-bit arithmetic
    assign target     = $signed({{(DW + 1 - PC_W){1'b0}}, r_pc}) + $signed({r_imm[DW-1], r_imm});
    assign jump_taken = is_jmp && !op_a[DW-1];
    assign jump_bad   = target[DW] || (target > TARGET_MAX);
    assign fault      = known && (idx_bad || (jump_taken && jump_bad));

    // step saturates at the program depth
    assign pc_inc = (r_pc >= PC_MAX) ? PC_MAX : (r_pc + PC_W'(1));

    always_comb begin
        if (!known || fault) begin
            n_pc = r_pc;
        end else if (jump_taken) begin
            n_pc = target[PC_W-1:0];
        end else begin
            n_pc = pc_inc;
        end
    end

    assign kind_eff = (known && !fault) ? kind : trm_pkg::PRINT_NONE;
    assign we       = exec_fire && known && !fault && wr_op;
    assign wr_idx   = r_rd[IDX_W-1:0];

    assign pc_cmp  = {{LW{1'b0}}, n_pc};
    assign len_cmp = {{PC_W{1'b0}}, r_prog_len};
    assign pc_out  = {{LW{1'b0}}, n_pc};

    // register file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_idx] <= wr_val;
        end
        if (in_fire) begin
            r_a_raw <= mem[i_dest_reg[IDX_W-1:0]];
            r_b_raw <= mem[i_src_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (we) begin
            r_reg_vld[wr_idx] <= 1'b1;
        end
    end

    // capture request and read-side bypass flags
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd      <= i_cmd;
            r_rd       <= i_dest_reg;
            r_rs       <= i_src_reg;
            r_imm      <= i_immediate;
            r_a_vld    <= r_reg_vld[i_dest_reg[IDX_W-1:0]];
            r_b_vld    <= r_reg_vld[i_src_reg[IDX_W-1:0]];
            r_a_fwd    <= we && (wr_idx == i_dest_reg[IDX_W-1:0]);
            r_b_fwd    <= we && (wr_idx == i_src_reg[IDX_W-1:0]);
            r_fwd_data <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_prog_len  <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                r_prog_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_next_pc <= pc_out[LW-1:0];
            r_kind    <= kind_eff;
            r_pval    <= (kind_eff != trm_pkg::PRINT_NONE) ? op_a : '0;
            r_done    <= (pc_cmp >= len_cmp);
            r_fault   <= fault;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_pc      = r_next_pc;
    assign o_print_kind   = r_kind;
    assign o_print_value  = r_pval;
    assign o_program_done = r_done;
    assign o_fault        = r_fault;

endmodule

`default_nettype wire

// ===== sv/trm_checker.sv =====
// Port-level checker for the execute core, bound to the top level.
`default_nettype none

module trm_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [trm_pkg::LEN_W-1:0]        o_next_pc,
    input wire logic [trm_pkg::KIND_W-1:0]       o_print_kind,
    input wire logic signed [trm_pkg::DATA_W-1:0] o_print_value,
    input wire logic                             o_fault
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_next_pc) && $stable(o_print_kind)
             && $stable(o_print_value) && $stable(o_fault)))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_print_kind <= trm_pkg::PRINT_CHAR))
        else $error("illegal print kind");

    a_quiet_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_print_kind == trm_pkg::PRINT_NONE) |-> (o_print_value == '0))
        else $error("print value without print");

    a_fault_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fault) |-> (o_print_kind == trm_pkg::PRINT_NONE))
        else $error("print on faulting instruction");

endmodule

bind toy_register_machine_execute_core trm_checker u_trm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_next_pc     (o_next_pc),
    .o_print_kind  (o_print_kind),
    .o_print_value (o_print_value),
    .o_fault       (o_fault)
);

`default_nettype wire

// ===== test/toy_register_machine_execute_core_tb.sv =====
// Testbench for the register machine execute core: directed table, random programs, predictor.
`timescale 1ns / 100ps

module toy_register_machine_execute_core_tb;

    localparam int NUM_REGS      = 13;
    localparam int PROGRAM_DEPTH = 256;
    localparam int REG_MAX       = (1 << trm_pkg::REG_W) - 1;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 7;

    // Opcodes the core does not decode.
    localparam logic [trm_pkg::CMD_W-1:0] OP_NOP        = 4'd0;
    localparam logic [trm_pkg::CMD_W-1:0] OP_UNKNOWN_LO = 4'd10;
    localparam logic [trm_pkg::CMD_W-1:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [trm_pkg::LEN_W-1:0]  next_pc;
        trm_pkg::t_print_kind       kind;
        logic [trm_pkg::DATA_W-1:0] value;
        logic                       done;
        logic                       fault;
    } t_outcome;

    typedef struct packed {
        logic [trm_pkg::CMD_W-1:0]  cmd;
        logic [trm_pkg::REG_W-1:0]  rd;
        logic [trm_pkg::REG_W-1:0]  rs;
        logic [trm_pkg::DATA_W-1:0] imm;
        logic                       typed;
        t_outcome                   want;
    } t_row;

    localparam t_outcome UNCHECKED = '{9'd0, trm_pkg::PRINT_NONE, 32'd0, 1'b0, 1'b0};

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [trm_pkg::CMD_W-1:0]         i_cmd;
    logic [trm_pkg::REG_W-1:0]         i_dest_reg;
    logic [trm_pkg::REG_W-1:0]         i_src_reg;
    logic signed [trm_pkg::DATA_W-1:0] i_immediate;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [trm_pkg::LEN_W-1:0]         i_cfg_data;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [trm_pkg::LEN_W-1:0]         o_next_pc;
    logic [trm_pkg::KIND_W-1:0]        o_print_kind;
    logic signed [trm_pkg::DATA_W-1:0] o_print_value;
    logic                              o_program_done;
    logic                              o_fault;

    // Machine state as the core should hold it.
    logic [trm_pkg::DATA_W-1:0] reg_model [NUM_REGS];
    int                         pc_model;
    logic [trm_pkg::LEN_W-1:0]  len_model;

    t_outcome pending_results[$];
    int       mismatches;
    int       burst_left;
    bit       gaps_on;
    bit       long_hold;

    // pc starts at 0 with program_length 5
    t_row directed_rows [0:23] = '{
        '{trm_pkg::OP_PTN, 4'd0,  4'd0,  32'h0000_0000, 1'b1,
          '{9'd1,   trm_pkg::PRINT_NUM,  32'h0, 1'b0, 1'b0}},
        '{OP_NOP, 4'd5,  4'd7,  32'hFFFF_FFFF, 1'b1,
          '{9'd1,   trm_pkg::PRINT_NONE, 32'h0, 1'b0, 1'b0}},
        '{OP_UNKNOWN_HI, 4'd15, 4'd15, 32'h0,  1'b1,
          '{9'd1,   trm_pkg::PRINT_NONE, 32'h0, 1'b0, 1'b0}},
        '{trm_pkg::OP_MOC, 4'd12, 4'd0,  32'h7FFF_FFFF, 1'b0, UNCHECKED},
        '{trm_pkg::OP_ADC, 4'd12, 4'd0,  32'h0000_0001, 1'b0, UNCHECKED},
        '{trm_pkg::OP_PTN, 4'd12, 4'd0,  32'h0000_0000, 1'b1,
          '{9'd4, trm_pkg::PRINT_NUM, 32'h8000_0000, 1'b0, 1'b0}},
        '{trm_pkg::OP_MOC, 4'd13, 4'd0,  32'h1234_5678, 1'b1,
          '{9'd4,   trm_pkg::PRINT_NONE, 32'h0, 1'b0, 1'b1}},
        '{trm_pkg::OP_MOV, 4'd0,  4'd15, 32'h0000_0000, 1'b1,
          '{9'd4,   trm_pkg::PRINT_NONE, 32'h0, 1'b0, 1'b1}},
        '{trm_pkg::OP_ADD, 4'd0,  4'd0,  32'h0000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_PTC, 4'd15, 4'd0,  32'h0000_0000, 1'b1,
          '{9'd5,   trm_pkg::PRINT_NONE, 32'h0, 1'b1, 1'b1}},
        '{trm_pkg::OP_MOC, 4'd1,  4'd0,  32'h8000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_SUC, 4'd1,  4'd0,  32'h0000_0001, 1'b0, UNCHECKED},
        '{trm_pkg::OP_SUB, 4'd2,  4'd1,  32'h0000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_PTC, 4'd2,  4'd0,  32'h0000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_JMP, 4'd2,  4'd0,  32'h0000_0064, 1'b0, UNCHECKED},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'hFFFF_FFF5, 1'b1,
          '{9'd10,  trm_pkg::PRINT_NONE, 32'h0, 1'b1, 1'b1}},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'h0000_00F6, 1'b0, UNCHECKED},
        '{trm_pkg::OP_ADC, 4'd0,  4'd0,  32'h0000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'h0000_0001, 1'b1,
          '{9'd256, trm_pkg::PRINT_NONE, 32'h0, 1'b1, 1'b1}},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'h8000_0000, 1'b1,
          '{9'd256, trm_pkg::PRINT_NONE, 32'h0, 1'b1, 1'b1}},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'hFFFF_FF00, 1'b0, UNCHECKED},
        '{trm_pkg::OP_MOV, 4'd3,  4'd12, 32'h0000_0000, 1'b0, UNCHECKED},
        '{trm_pkg::OP_JMP, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b1,
          '{9'd1,   trm_pkg::PRINT_NONE, 32'h0, 1'b0, 1'b1}},
        '{trm_pkg::OP_JMP, 4'd12, 4'd0,  32'h0000_0005, 1'b0, UNCHECKED}
    };

    toy_register_machine_execute_core #(
        .NUM_REGS      (NUM_REGS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_dest_reg     (i_dest_reg),
        .i_src_reg      (i_src_reg),
        .i_immediate    (i_immediate),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_pc      (o_next_pc),
        .o_print_kind   (o_print_kind),
        .o_print_value  (o_print_value),
        .o_program_done (o_program_done),
        .o_fault        (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Execute one instruction on the machine state and return its outcome.
    function automatic t_outcome execute_instr(input logic [trm_pkg::CMD_W-1:0] cmd,
                                               input logic [trm_pkg::REG_W-1:0] rd,
                                               input logic [trm_pkg::REG_W-1:0] rs,
                                               input logic [trm_pkg::DATA_W-1:0] imm);
        t_outcome                   res;
        logic                       uses_src;
        logic [trm_pkg::DATA_W-1:0] a;
        logic [trm_pkg::DATA_W-1:0] b;
        longint                     target;
        int                         pc;
        res = UNCHECKED;
        pc = pc_model;
        uses_src = (cmd == trm_pkg::OP_MOV) || (cmd == trm_pkg::OP_ADD)
                   || (cmd == trm_pkg::OP_SUB);
        if (cmd >= trm_pkg::OP_MOV && cmd <= trm_pkg::OP_PTC) begin
            if (rd >= NUM_REGS || (uses_src && rs >= NUM_REGS)) begin
                res.fault = 1'b1;
            end else begin
                a = reg_model[rd];
                b = uses_src ? reg_model[rs] : '0;
                case (cmd)
                    trm_pkg::OP_MOV: reg_model[rd] = b;
                    trm_pkg::OP_MOC: reg_model[rd] = imm;
                    trm_pkg::OP_ADD: reg_model[rd] = a + b;
                    trm_pkg::OP_ADC: reg_model[rd] = a + imm;
                    trm_pkg::OP_SUB: reg_model[rd] = a - b;
                    trm_pkg::OP_SUC: reg_model[rd] = a - imm;
                    trm_pkg::OP_JMP: ;
                    trm_pkg::OP_PTN: begin
                        res.kind = trm_pkg::PRINT_NUM;
                        res.value = a;
                    end
                    default: begin
                        res.kind = trm_pkg::PRINT_CHAR;
                        res.value = a;
                    end
                endcase
                if (cmd == trm_pkg::OP_JMP && !a[trm_pkg::DATA_W-1]) begin
                    target = longint'(pc) + longint'($signed(imm));
                    if (target < 0 || target > PROGRAM_DEPTH)
                        res.fault = 1'b1;
                    else
                        pc = int'(target);
                end else begin
                    // step saturates at the end of program memory
                    pc = (pc >= PROGRAM_DEPTH) ? PROGRAM_DEPTH : pc + 1;
                end
            end
        end
        pc_model = pc;
        res.next_pc = pc[trm_pkg::LEN_W-1:0];
        res.done = (pc >= len_model);
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [trm_pkg::DATA_W-1:0] got,
                                   input logic [trm_pkg::DATA_W-1:0] want);
        $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one request, wait for it to be taken, and queue its outcome.
    task automatic send_instr(input logic [trm_pkg::CMD_W-1:0] cmd,
                              input logic [trm_pkg::REG_W-1:0] rd,
                              input logic [trm_pkg::REG_W-1:0] rs,
                              input logic [trm_pkg::DATA_W-1:0] imm,
                              input logic typed, input t_outcome want);
        t_outcome predicted;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_dest_reg  <= rd;
        i_src_reg   <= rs;
        i_immediate <= imm;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = execute_instr(cmd, rd, rs, imm);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every queued outcome has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [trm_pkg::LEN_W-1:0] len);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        len_model = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_instr();
        logic [trm_pkg::CMD_W-1:0]  cmd;
        logic [trm_pkg::REG_W-1:0]  rd;
        logic [trm_pkg::REG_W-1:0]  rs;
        logic [trm_pkg::DATA_W-1:0] imm;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            cmd = OP_NOP;
        else if (pick < 7)
            cmd = trm_pkg::CMD_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        else if (pick < 20)
            cmd = trm_pkg::OP_JMP;
        else
            cmd = trm_pkg::CMD_W'($urandom_range(trm_pkg::OP_MOV, trm_pkg::OP_PTC));
        rd = ($urandom_range(0, 9) == 0)
             ? trm_pkg::REG_W'($urandom_range(NUM_REGS, REG_MAX))
             : trm_pkg::REG_W'($urandom_range(0, NUM_REGS - 1));
        rs = ($urandom_range(0, 9) == 0)
             ? trm_pkg::REG_W'($urandom_range(NUM_REGS, REG_MAX))
             : trm_pkg::REG_W'($urandom_range(0, NUM_REGS - 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: imm = $urandom;
            4, 5, 6:    imm = trm_pkg::DATA_W'($urandom_range(0, 40)) - 32'd20;
            7: begin
                case ($urandom_range(0, 3))
                    0:       imm = 32'h7FFF_FFFF;
                    1:       imm = 32'h8000_0000;
                    2:       imm = 32'hFFFF_FFFF;
                    default: imm = 32'h0000_0000;
                endcase
            end
            // offset that lands anywhere inside program memory
            default: imm = trm_pkg::DATA_W'($urandom_range(0, PROGRAM_DEPTH))
                           - trm_pkg::DATA_W'(pc_model);
        endcase
        send_instr(cmd, rd, rs, imm, 1'b0, UNCHECKED);
    endtask

    // Receiver: stall on a changing pattern, or hold off for a long stretch on request.
    initial begin
        int mode;
        int mode_left;
        int tick;
        i_out_ready = 1'b0;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 9) != 0);
                    default: i_out_ready <= ((tick % 4) != 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, next_pc", 32'(o_next_pc), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(o_next_pc), 32'(want.next_pc));
                if (o_print_kind !== want.kind)
                    report_mismatch("print_kind", 32'(o_print_kind), 32'(want.kind));
                if (o_print_value !== want.value)
                    report_mismatch("print_value", o_print_value, want.value);
                if (o_program_done !== want.done)
                    report_mismatch("program_done", 32'(o_program_done), 32'(want.done));
                if (o_fault !== want.fault)
                    report_mismatch("fault", 32'(o_fault), 32'(want.fault));
            end
        end
    end

    initial begin
        logic [trm_pkg::LEN_W-1:0] phase_len [NUM_PHASES];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = OP_NOP;
        i_dest_reg  = '0;
        i_src_reg   = '0;
        i_immediate = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        mismatches  = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        long_hold   = 1'b0;
        pc_model    = 0;
        len_model   = '0;
        foreach (reg_model[k]) reg_model[k] = '0;
        phase_len = '{9'd0, 9'd256, 9'd255, 9'd1,
                      trm_pkg::LEN_W'($urandom_range(2, 254)), 9'd128, 9'd256};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_length(9'd5);
        foreach (directed_rows[k])
            send_instr(directed_rows[k].cmd, directed_rows[k].rd, directed_rows[k].rs,
                       directed_rows[k].imm, directed_rows[k].typed, directed_rows[k].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_length(phase_len[ph]);
            if (ph == 2) begin
                // keep offering while the output is held off so the input backs up
                gaps_on = 1'b0;
                long_hold = 1'b1;
                repeat (30) random_instr();
            end
            gaps_on = (ph != 3);
            repeat (PHASE_ITEMS) random_instr();
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
